/* hw/rtl/fftmag_pkg.sv */
// ----------------------------------------------------------------------------
// fftmag_pkg
// Shared types, constants and twiddle generation for the magnitude spectrum
// block.
// ----------------------------------------------------------------------------
package fftmag_pkg;

	localparam int POINTS_DEF    = 256;
	localparam int WORK_BITS_DEF = 32;

	localparam int SAMPLE_W = 10;
	localparam int BIN_W    = 8;
	localparam int MAG_W    = 10;
	localparam int HELD_W   = 9;
	localparam int TW_W     = 16;

	localparam logic [MAG_W-1:0] MAG_MAX = 10'd1023;
	localparam logic [63:0]      PI_Q30  = 64'd3373259426;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample;
		logic [BIN_W-1:0]    bin_index;
	} in_word_t;

	typedef struct packed {
		logic [MAG_W-1:0]  magnitude;
		logic              spectrum_valid;
		logic              frame_done;
		logic [HELD_W-1:0] samples_held;
	} out_word_t;

	// Butterfly stage enables
	typedef struct packed {
		logic mul;
		logic add;
	} bf_ctl_t;

	// Round a Q30 value half up to Q15, clamp to [0, 32767]
	function automatic logic [TW_W-1:0] q30_to_q15(input logic signed [63:0] v);
		logic signed [63:0] r;
		begin
			r = (v < 0) ? 64'sd0 : v;
			r = (r + 64'sd16384) >>> 15;
			if (r > 64'sd32767)
				r = 64'sd32767;
			return TW_W'(r);
		end
	endfunction

	// Twiddle for angle pi*t/2^logn: {cos, sin} in Q1.15, sin never negative
	function automatic logic [2*TW_W-1:0] tw_entry(input int unsigned t,
		input int unsigned logn);
		logic [63:0]        n;
		logic [63:0]        k;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic               cneg;
		logic [TW_W-1:0]    cq;
		logic [TW_W-1:0]    sq;
		begin
			n    = 64'd1 << logn;
			k    = 64'(t);
			cneg = 1'b0;
			if (2 * k > n) begin
				k    = n - k;
				cneg = 1'b1;
			end
			x  = (PI_Q30 * k) >> logn;
			x2 = (x * x) >> 30;
			// sine series
			term = x;
			s    = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;   s = s - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;  s = s + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;  s = s - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;  s = s + $signed(term);
			term = ((term * x2) >> 30) / 64'd110; s = s - $signed(term);
			term = ((term * x2) >> 30) / 64'd156; s = s + $signed(term);
			// cosine series
			term = 64'd1 << 30;
			c    = $signed(term);
			term = ((term * x2) >> 30) / 64'd2;   c = c - $signed(term);
			term = ((term * x2) >> 30) / 64'd12;  c = c + $signed(term);
			term = ((term * x2) >> 30) / 64'd30;  c = c - $signed(term);
			term = ((term * x2) >> 30) / 64'd56;  c = c + $signed(term);
			term = ((term * x2) >> 30) / 64'd90;  c = c - $signed(term);
			term = ((term * x2) >> 30) / 64'd132; c = c + $signed(term);
			sq = q30_to_q15(s);
			cq = q30_to_q15(c);
			if (cneg)
				cq = -cq;
			return {cq, sq};
		end
	endfunction

endpackage

/* hw/rtl/fftmag_twiddle_rom.sv */
// ----------------------------------------------------------------------------
// fftmag_twiddle_rom
// Constant cos/sin table over half a turn, registered read.
// ----------------------------------------------------------------------------
module fftmag_twiddle_rom #(
	parameter int LOGN = 7
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [LOGN-1:0]                     addr,
	output logic signed [fftmag_pkg::TW_W-1:0]  cos_q,
	output logic signed [fftmag_pkg::TW_W-1:0]  sin_q
);
	import fftmag_pkg::*;

	localparam int N = 1 << LOGN;

	logic [2*TW_W-1:0] rom [N];

	// Fill table at elaboration
	for (genvar t = 0; t < N; t++) begin : g_rom
		assign rom[t] = tw_entry(t, LOGN);
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= rom[addr][2*TW_W-1:TW_W];
			sin_q <= rom[addr][TW_W-1:0];
		end
	end

endmodule

/* hw/rtl/fftmag_butterfly.sv */
// ----------------------------------------------------------------------------
// fftmag_butterfly
// Radix-2 butterfly: twiddle products in one stage, floor shift and
// sum/difference in the next.
// ----------------------------------------------------------------------------
module fftmag_butterfly #(
	parameter int WB = 32
) (
	input  logic                               clk,
	input  fftmag_pkg::bf_ctl_t                ctl,
	input  logic signed [WB-1:0]               p_re,
	input  logic signed [WB-1:0]               p_im,
	input  logic signed [WB-1:0]               q_re,
	input  logic signed [WB-1:0]               q_im,
	input  logic signed [fftmag_pkg::TW_W-1:0] tw_cos,
	input  logic signed [fftmag_pkg::TW_W-1:0] tw_sin,
	output logic signed [WB-1:0]               np_re,
	output logic signed [WB-1:0]               np_im,
	output logic signed [WB-1:0]               nq_re,
	output logic signed [WB-1:0]               nq_im
);
	import fftmag_pkg::*;

	localparam int PW = WB + TW_W;

	logic signed [PW-1:0] crr_s1, sii_s1, cii_s1, srr_s1;
	logic signed [PW:0]   sum_re, sum_im, shr_re, shr_im;
	logic signed [WB-1:0] t_re, t_im;
	logic signed [WB-1:0] pr_s2, pi_s2, qr_s2, qi_s2;

	// Twiddle products
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			crr_s1 <= tw_cos * q_re;
			sii_s1 <= tw_sin * q_im;
			cii_s1 <= tw_cos * q_im;
			srr_s1 <= tw_sin * q_re;
		end
	end

	// W = cos - j*sin: t = W*q, shifted toward minus infinity
	assign sum_re = crr_s1 + sii_s1;
	assign sum_im = cii_s1 - srr_s1;
	assign shr_re = sum_re >>> 15;
	assign shr_im = sum_im >>> 15;
	assign t_re   = shr_re[WB-1:0];
	assign t_im   = shr_im[WB-1:0];

	// Sum and difference, wrapping to the working width
	always_ff @(posedge clk) begin
		if (ctl.add) begin
			pr_s2 <= p_re + t_re;
			pi_s2 <= p_im + t_im;
			qr_s2 <= p_re - t_re;
			qi_s2 <= p_im - t_im;
		end
	end

	assign np_re = pr_s2;
	assign np_im = pi_s2;
	assign nq_re = qr_s2;
	assign nq_im = qi_s2;

endmodule

/* hw/rtl/fftmag_isqrt.sv */
// ----------------------------------------------------------------------------
// fftmag_isqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module fftmag_isqrt #(
	parameter int RB = 19
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RB-1:0] radicand,
	output logic            done,
	output logic [RB-1:0]   root
);
	import fftmag_pkg::*;

	localparam int CW = $clog2(RB);

	logic            run_q, done_q;
	logic [CW-1:0]   cnt_q;
	logic [2*RB-1:0] rad_q;
	logic [RB+1:0]   rem_q;
	logic [RB-1:0]   root_q;
	logic [RB+1:0]   rem_next, trial;
	logic            ge;

	// Trial subtract of the next root bit
	assign rem_next = {rem_q[RB-1:0], rad_q[2*RB-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign ge       = rem_next >= trial;

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(RB - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_next - trial : rem_next;
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hw/rtl/fft_spectrum_magnitude.sv */
// ----------------------------------------------------------------------------
// fft_spectrum_magnitude
// Collects a frame of real samples, runs an in-place radix-2 FFT out of a
// working memory and keeps the per-bin magnitudes for reads by index.
// ----------------------------------------------------------------------------
//  channel | direction | word type  | handshake
//  req     | in        | in_word_t  | req_valid / req_stall
//  rsp     | out       | out_word_t | rsp_valid / rsp_stall
//
// A push is taken in the idle state; a bin read goes through the magnitude
// memory read and then a read state. The push that completes a frame runs
// the butterflies (one shared butterfly unit, one write port on the working
// memory) and then the magnitudes (bit-serial square root) before another
// word is taken.
// Reset clears the sample count and the spectrum flag; the memories hold no
// reset. A stalled result is held in the output register; a new word is taken
// only once that register is free or being taken.
// ----------------------------------------------------------------------------
module fft_spectrum_magnitude #(
	parameter int POINTS    = fftmag_pkg::POINTS_DEF,
	parameter int WORK_BITS = fftmag_pkg::WORK_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  fftmag_pkg::in_word_t  req_word,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output fftmag_pkg::out_word_t rsp_word
);
	import fftmag_pkg::*;

	localparam int WB   = WORK_BITS;
	localparam int LOGP = $clog2(POINTS);
	localparam int LOGN = LOGP - 1;
	localparam int SW   = $clog2(LOGP);
	localparam int AW   = LOGP + 10;
	localparam int RB   = LOGP + 11;
	localparam int IXW  = (LOGP > BIN_W) ? LOGP : BIN_W;

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_READ    = 13'b0000000000010,
		ST_BF_RD   = 13'b0000000000100,
		ST_BF_MUL  = 13'b0000000001000,
		ST_BF_ADD  = 13'b0000000010000,
		ST_BF_WQ   = 13'b0000000100000,
		ST_BF_WP   = 13'b0000001000000,
		ST_MG_RD   = 13'b0000010000000,
		ST_MG_ABS  = 13'b0000100000000,
		ST_MG_SQR  = 13'b0001000000000,
		ST_MG_SUM  = 13'b0010000000000,
		ST_MG_ROOT = 13'b0100000000000,
		ST_SPARE   = 13'b1000000000000
	} state_t;

	state_t          st_q;
	logic [LOGP:0]   cnt_q;
	logic            ready_q;
	logic [SW-1:0]   stg_q;
	logic [LOGN-1:0] j_q;
	logic [LOGP-1:0] bin_q;
	logic            rd_ok_q;
	logic            rsp_valid_q;
	out_word_t       rsp_word_q;

	// Memories and read data
	logic [2*WB-1:0] work_mem [POINTS];
	logic [MAG_W-1:0] mag_mem [POINTS];
	logic [2*WB-1:0] rd_a_q, rd_b_q;
	logic [MAG_W-1:0] mg_rd_q;

	logic            accept;
	logic [LOGP-1:0] push_idx, push_rev;
	logic [LOGP:0]   push_cnt;
	logic            last_push;
	logic signed [WB-1:0] smp_ext, push_re;
	logic [IXW-1:0]  ix;
	logic            in_range;

	logic [LOGN:0]   m_one;
	logic [LOGN-1:0] low;
	logic [LOGP-1:0] p_addr, q_addr;
	logic [LOGN-1:0] tw_addr;

	logic            wr_en, rd_en, tw_en, mg_rd_en, mg_wr_en, sq_start, load;
	logic [LOGP-1:0] wr_addr, rd_a_addr, rd_b_addr;
	logic [2*WB-1:0] wr_data;
	out_word_t       load_word;
	bf_ctl_t         bf_ctl;

	logic signed [TW_W-1:0] tw_cos, tw_sin;
	logic signed [WB-1:0]   np_re, np_im, nq_re, nq_im;

	logic signed [WB-1:0] a_re, a_im;
	logic [WB-1:0]        abs_re, abs_im;
	logic [AW-1:0]        abs_a_q, abs_b_q;
	logic                 sat_q;
	logic [2*AW-1:0]      sq_a_q, sq_b_q;
	logic                 sq_done;
	logic [RB-1:0]        sq_root;
	logic [RB-LOGP-1:0]   scaled;
	logic [MAG_W-1:0]     mag_val;

	assign accept    = req_valid && !req_stall;
	assign req_stall = !((st_q == ST_IDLE) && (!rsp_valid_q || !rsp_stall));

	// Push slot, count and stored value (even slots negated)
	assign push_idx  = (cnt_q == (LOGP+1)'(POINTS)) ? '0 : cnt_q[LOGP-1:0];
	assign push_cnt  = (LOGP+1)'(push_idx) + 1'b1;
	assign last_push = push_cnt == (LOGP+1)'(POINTS);
	assign smp_ext   = WB'(req_word.sample);
	assign push_re   = push_idx[0] ? smp_ext : -smp_ext;

	// Store in bit-reversed order so the FFT runs on the reordered frame
	always_comb begin
		for (int b = 0; b < LOGP; b++)
			push_rev[b] = push_idx[LOGP-1-b];
	end

	// Bin address and range
	assign ix       = IXW'(req_word.bin_index);
	assign in_range = (IXW+1)'(req_word.bin_index) < (IXW+1)'(POINTS);

	// Butterfly addresses for this stage
	assign m_one   = (LOGN+1)'(1) << stg_q;
	assign low     = LOGN'(m_one - 1'b1);
	assign p_addr  = {j_q & ~low, 1'b0} | {1'b0, j_q & low};
	assign q_addr  = p_addr | m_one;
	assign tw_addr = LOGN'((j_q & low) << (SW'(LOGN) - stg_q));

	// Magnitude from square root: scale by frame size, saturate
	assign scaled  = sq_root[RB-1:LOGP];
	assign mag_val = (sat_q || scaled[MAG_W]) ? MAG_MAX : scaled[MAG_W-1:0];

	// Per-state memory and unit controls
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = q_addr;
		wr_data   = {nq_re, nq_im};
		rd_en     = 1'b0;
		rd_a_addr = p_addr;
		rd_b_addr = q_addr;
		tw_en     = 1'b0;
		mg_rd_en  = 1'b0;
		mg_wr_en  = 1'b0;
		sq_start  = 1'b0;
		bf_ctl    = '0;
		load      = 1'b0;
		load_word = '0;
		load_word.spectrum_valid = ready_q;
		load_word.samples_held   = HELD_W'(cnt_q);
		case (st_q)
			ST_IDLE: begin
				if (accept && req_word.cmd == CMD_PUSH) begin
					wr_en   = 1'b1;
					wr_addr = push_rev;
					wr_data = {push_re, WB'(0)};
					load    = !last_push;
					load_word.samples_held = HELD_W'(push_cnt);
				end
				if (accept && req_word.cmd == CMD_READ)
					mg_rd_en = 1'b1;
			end
			ST_READ: begin
				load = 1'b1;
				load_word.magnitude = rd_ok_q ? mg_rd_q : '0;
			end
			ST_BF_RD: begin
				rd_en = 1'b1;
				tw_en = 1'b1;
			end
			ST_BF_MUL: bf_ctl.mul = 1'b1;
			ST_BF_ADD: bf_ctl.add = 1'b1;
			ST_BF_WQ:  wr_en = 1'b1;
			ST_BF_WP: begin
				wr_en   = 1'b1;
				wr_addr = p_addr;
				wr_data = {np_re, np_im};
			end
			ST_MG_RD: begin
				rd_en     = 1'b1;
				rd_a_addr = bin_q;
			end
			ST_MG_SUM: sq_start = 1'b1;
			ST_MG_ROOT: begin
				if (sq_done) begin
					mg_wr_en = 1'b1;
					if (bin_q == '1) begin
						load = 1'b1;
						load_word.spectrum_valid = 1'b1;
						load_word.frame_done     = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			stg_q       <= '0;
			j_q         <= '0;
			bin_q       <= '0;
			rd_ok_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept && req_word.cmd == CMD_PUSH) begin
						cnt_q <= push_cnt;
						if (last_push) begin
							st_q  <= ST_BF_RD;
							stg_q <= '0;
							j_q   <= '0;
						end
					end else if (accept) begin
						rd_ok_q <= ready_q && in_range;
						st_q    <= ST_READ;
					end
				end
				ST_READ:   st_q <= ST_IDLE;
				ST_BF_RD:  st_q <= ST_BF_MUL;
				ST_BF_MUL: st_q <= ST_BF_ADD;
				ST_BF_ADD: st_q <= ST_BF_WQ;
				ST_BF_WQ:  st_q <= ST_BF_WP;
				ST_BF_WP: begin
					if (j_q == '1) begin
						j_q <= '0;
						if (stg_q == SW'(LOGP - 1)) begin
							bin_q <= '0;
							st_q  <= ST_MG_RD;
						end else begin
							stg_q <= stg_q + 1'b1;
							st_q  <= ST_BF_RD;
						end
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= ST_BF_RD;
					end
				end
				ST_MG_RD:  st_q <= ST_MG_ABS;
				ST_MG_ABS: st_q <= ST_MG_SQR;
				ST_MG_SQR: st_q <= ST_MG_SUM;
				ST_MG_SUM: st_q <= ST_MG_ROOT;
				ST_MG_ROOT: begin
					if (sq_done) begin
						if (bin_q == '1) begin
							ready_q <= 1'b1;
							st_q    <= ST_IDLE;
						end else begin
							bin_q <= bin_q + 1'b1;
							st_q  <= ST_MG_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// Output register: load a result, drop it once taken
			if (load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Hold the result word
	always_ff @(posedge clk) begin
		if (load)
			rsp_word_q <= load_word;
	end

	// Working memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en)
			work_mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_a_q <= work_mem[rd_a_addr];
			rd_b_q <= work_mem[rd_b_addr];
		end
	end

	// Magnitude memory
	always_ff @(posedge clk) begin
		if (mg_wr_en)
			mag_mem[bin_q] <= mag_val;
		if (mg_rd_en)
			mg_rd_q <= mag_mem[ix[LOGP-1:0]];
	end

	// Magnitude front end: absolute values, saturation check, squares
	assign a_re   = rd_a_q[2*WB-1:WB];
	assign a_im   = rd_a_q[WB-1:0];
	assign abs_re = a_re[WB-1] ? WB'(-a_re) : WB'(a_re);
	assign abs_im = a_im[WB-1] ? WB'(-a_im) : WB'(a_im);

	always_ff @(posedge clk) begin
		if (st_q == ST_MG_ABS) begin
			abs_a_q <= abs_re[AW-1:0];
			abs_b_q <= abs_im[AW-1:0];
			sat_q   <= (|abs_re[WB-1:AW]) || (|abs_im[WB-1:AW]);
		end
		if (st_q == ST_MG_SQR) begin
			sq_a_q <= abs_a_q * abs_a_q;
			sq_b_q <= abs_b_q * abs_b_q;
		end
	end

	fftmag_twiddle_rom #(
		.LOGN (LOGN)
	) u_rom (
		.clk   (clk),
		.en    (tw_en),
		.addr  (tw_addr),
		.cos_q (tw_cos),
		.sin_q (tw_sin)
	);

	fftmag_butterfly #(
		.WB (WB)
	) u_bf (
		.clk    (clk),
		.ctl    (bf_ctl),
		.p_re   (rd_a_q[2*WB-1:WB]),
		.p_im   (rd_a_q[WB-1:0]),
		.q_re   (rd_b_q[2*WB-1:WB]),
		.q_im   (rd_b_q[WB-1:0]),
		.tw_cos (tw_cos),
		.tw_sin (tw_sin),
		.np_re  (np_re),
		.np_im  (np_im),
		.nq_re  (nq_re),
		.nq_im  (nq_im)
	);

	fftmag_isqrt #(
		.RB (RB)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ((2*RB)'(sq_a_q) + (2*RB)'(sq_b_q)),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

/* hw/rtl/fftmag_checker.sv */
// ----------------------------------------------------------------------------
// fftmag_checker
// Port-level checks of the magnitude spectrum block, bound to the top level.
// ----------------------------------------------------------------------------
module fftmag_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input fftmag_pkg::in_word_t  req_word,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input fftmag_pkg::out_word_t rsp_word
);
	import fftmag_pkg::*;

	logic seen_q;

	// Remember that a completed spectrum was reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (rsp_valid && !rsp_stall && rsp_word.spectrum_valid)
			seen_q <= 1'b1;
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.cmd == CMD_READ |=> req_stall)
		else $error("word taken during a bin read");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.frame_done |->
			rsp_word.spectrum_valid && rsp_word.magnitude == '0)
		else $error("frame completion without spectrum");

	a_no_spec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.spectrum_valid |-> rsp_word.magnitude == '0)
		else $error("magnitude before any spectrum");

	a_spec_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_q |-> rsp_word.spectrum_valid)
		else $error("spectrum flag dropped");

endmodule

bind fft_spectrum_magnitude fftmag_checker u_fftmag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_word  (req_word),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);

/* verif/fft_spectrum_magnitude_test.sv */
// ----------------------------------------------------------------------------
// fft_spectrum_magnitude_test
// Self-checking bench for the magnitude spectrum block: pushes sample frames,
// the last one partial, and bin reads through the request channel; predicts
// each response word with its own fixed-point FFT, compares field by field.
// ----------------------------------------------------------------------------
module fft_spectrum_magnitude_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fftmag_pkg::*;

	localparam int NPTS      = 256;
	localparam int LOG_NPTS  = 8;
	localparam int CYC_LIMIT = 400000;
	localparam int DRAIN     = 60;

	// Frame content patterns
	typedef enum int {FR_RANDOM, FR_ALTERNATE, FR_FULL_SCALE} frame_kind_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_word_t  req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_word_t rsp_word;

	fft_spectrum_magnitude u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #6 clk = ~clk;

	in_word_t  pending_words[$];
	out_word_t expected_rsp[$];
	bit        failed = 1'b0;
	int        cycle_count = 0;

	// Spectrum state
	longint        frame_re[NPTS];
	longint        frame_im[NPTS];
	bit [MAG_W-1:0] bin_mag[NPTS];
	int            held_count = 0;
	bit            have_spectrum = 1'b0;

	function automatic longint wrap32(longint v);
		return longint'($signed(v[31:0]));
	endfunction

	function automatic longint q15_round(longint v);
		longint r;
		r = (v < 0) ? 0 : v;
		r = (r + 16384) >>> 15;
		return (r > 32767) ? 32767 : r;
	endfunction

	// cos and sin of pi*g/m in Q1.15 via Taylor series in Q30
	task automatic twiddle_q15(input int unsigned g, input int unsigned m,
		output longint cq, output longint sq);
		longint unsigned k, x, x2, term;
		longint          s, c;
		bit              cneg;
		k    = g;
		cneg = 1'b0;
		if (2 * g > m) begin
			k    = m - g;
			cneg = 1'b1;
		end
		x  = (64'd3373259426 * k) / m;
		x2 = (x * x) >> 30;
		term = x;
		s    = longint'(x);
		for (int i = 1; i <= 6; i++) begin
			term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
			if (i % 2) s -= longint'(term);
			else s += longint'(term);
		end
		term = 64'd1 << 30;
		c    = longint'(term);
		for (int i = 1; i <= 6; i++) begin
			term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
			if (i % 2) c -= longint'(term);
			else c += longint'(term);
		end
		sq = q15_round(s);
		cq = cneg ? -q15_round(c) : q15_round(c);
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v  -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Negate even samples, reorder, run the butterflies, keep magnitudes
	task automatic compute_spectrum();
		int     j, q;
		longint t, wr, wi, cq, sq, tr, ti;
		longint unsigned a, b, r;
		for (int i = 0; i < NPTS; i += 2) begin
			frame_re[i] = wrap32(-frame_re[i]);
			frame_im[i] = wrap32(-frame_im[i]);
		end
		for (int i = 0; i < NPTS; i++) begin
			j = 0;
			for (int bt = 0; bt < LOG_NPTS; bt++)
				if (i & (1 << bt)) j |= 1 << (LOG_NPTS - 1 - bt);
			if (j > i) begin
				t = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = t;
				t = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = t;
			end
		end
		for (int m = 1; m < NPTS; m <<= 1) begin
			for (int g = 0; g < m; g++) begin
				twiddle_q15(g, m, cq, sq);
				wr = cq;
				wi = -sq;
				for (int p = g; p + m < NPTS; p += 2 * m) begin
					q  = p + m;
					tr = wrap32((wr * frame_re[q] - wi * frame_im[q]) >>> 15);
					ti = wrap32((wi * frame_re[q] + wr * frame_im[q]) >>> 15);
					frame_re[q] = wrap32(frame_re[p] - tr);
					frame_im[q] = wrap32(frame_im[p] - ti);
					frame_re[p] = wrap32(frame_re[p] + tr);
					frame_im[p] = wrap32(frame_im[p] + ti);
				end
			end
		end
		for (int i = 0; i < NPTS; i++) begin
			a = (frame_re[i] < 0) ? -frame_re[i] : frame_re[i];
			b = (frame_im[i] < 0) ? -frame_im[i] : frame_im[i];
			if (a >= 1024 * NPTS || b >= 1024 * NPTS) begin
				bin_mag[i] = MAG_MAX;
			end else begin
				r = int_sqrt(a * a + b * b) / NPTS;
				bin_mag[i] = (r > 1023) ? MAG_MAX : MAG_W'(r);
			end
		end
	endtask

	// Work out the response to one accepted word
	task automatic predict_response(input in_word_t w);
		out_word_t o;
		o = '0;
		if (w.cmd == CMD_PUSH) begin
			if (held_count >= NPTS) held_count = 0;
			frame_re[held_count] = longint'(w.sample);
			frame_im[held_count] = 0;
			held_count++;
			if (held_count == NPTS) begin
				compute_spectrum();
				have_spectrum = 1'b1;
				o.frame_done  = 1'b1;
			end
		end else if (have_spectrum) begin
			o.magnitude = bin_mag[w.bin_index];
		end
		o.spectrum_valid = have_spectrum;
		o.samples_held   = HELD_W'(held_count);
		expected_rsp.push_back(o);
	endtask

	function automatic in_word_t make_word(logic c, int smp, int idx);
		in_word_t w;
		w.cmd       = c;
		w.sample    = SAMPLE_W'(smp);
		w.bin_index = BIN_W'(idx);
		return w;
	endfunction

	function automatic int random_sample();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// Queue pushes of one frame with reads sprinkled in between
	task automatic queue_frame(input int count, input frame_kind_t kind);
		int smp;
		for (int i = 0; i < count; i++) begin
			case (kind)
				FR_ALTERNATE:  smp = (i % 2) ? 0 : 1023;
				FR_FULL_SCALE: smp = 1023;
				default:       smp = random_sample();
			endcase
			pending_words.push_back(make_word(CMD_PUSH, smp, $urandom_range(0, 255)));
			if ($urandom_range(0, 15) == 0)
				pending_words.push_back(make_word(CMD_READ, $urandom_range(0, 1023),
					$urandom_range(0, 255)));
		end
	endtask

	function automatic int gap_length();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// Request driver: hold a stalled word, insert gaps, advance from the queue
	int req_gap = 0;
	always @(posedge clk) begin
		if (arst_n && (!req_valid || !req_stall)) begin
			if (req_gap > 0) begin
				req_gap   <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				req_word  <= pending_words.pop_front();
				req_valid <= 1'b1;
				if ((cycle_count / 300) % 3 != 0 && $urandom_range(0, 2) == 0)
					req_gap <= gap_length();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Predict on every accepted request word
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			predict_response(req_word);
	end

	// Response stall pattern, with quiet stretches
	int stall_left = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if ((cycle_count / 250) % 3 != 1 && $urandom_range(0, 3) == 0) begin
			stall_left <= gap_length();
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare each accepted response word with the oldest expectation
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected response word %h", rsp_word);
				failed = 1'b1;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp_word.magnitude !== e.magnitude) begin
					$error("magnitude: expected %0d, got %0d", e.magnitude, rsp_word.magnitude);
					failed = 1'b1;
				end
				if (rsp_word.spectrum_valid !== e.spectrum_valid) begin
					$error("spectrum_valid: expected %0d, got %0d", e.spectrum_valid,
						rsp_word.spectrum_valid);
					failed = 1'b1;
				end
				if (rsp_word.frame_done !== e.frame_done) begin
					$error("frame_done: expected %0d, got %0d", e.frame_done,
						rsp_word.frame_done);
					failed = 1'b1;
				end
				if (rsp_word.samples_held !== e.samples_held) begin
					$error("samples_held: expected %0d, got %0d", e.samples_held,
						rsp_word.samples_held);
					failed = 1'b1;
				end
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		if (cycle_count >= CYC_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		frame_kind_t first_kind;
		// Reads before any spectrum, index extremes
		pending_words.push_back(make_word(CMD_READ, 0, 0));
		pending_words.push_back(make_word(CMD_READ, 1023, 255));
		pending_words.push_back(make_word(CMD_READ, 'h155, 'h55));
		pending_words.push_back(make_word(CMD_READ, 'h2AA, 'hAA));
		// Sample extremes open the first frame
		pending_words.push_back(make_word(CMD_PUSH, 0, 255));
		pending_words.push_back(make_word(CMD_PUSH, 1023, 0));
		pending_words.push_back(make_word(CMD_PUSH, 'h155, 'hAA));
		pending_words.push_back(make_word(CMD_PUSH, 'h2AA, 'h55));
		first_kind = frame_kind_t'($urandom_range(0, 2));
		queue_frame(NPTS - 4, first_kind);
		// Read DC, Nyquist and edge bins of the fresh spectrum
		pending_words.push_back(make_word(CMD_READ, 0, 0));
		pending_words.push_back(make_word(CMD_READ, 0, 128));
		pending_words.push_back(make_word(CMD_READ, 0, 255));
		pending_words.push_back(make_word(CMD_READ, 0, 1));
		queue_frame(NPTS, (first_kind == FR_RANDOM) ?
			frame_kind_t'($urandom_range(0, 2)) : FR_RANDOM);
		for (int i = 0; i < 10; i++)
			pending_words.push_back(make_word(CMD_READ, $urandom_range(0, 1023),
				$urandom_range(0, 255)));
		// Partial frame: old spectrum stays readable
		queue_frame(8, FR_RANDOM);
		for (int i = 0; i < 10; i++)
			pending_words.push_back(make_word(CMD_READ, $urandom_range(0, 1023),
				$urandom_range(0, 255)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (!failed && expected_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
